// ----- hdl/btrm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btrm_pkg
// Shared widths, register indexes and types of the transition rarity monitor.
// ----------------------------------------------------------------------------
package btrm_pkg;
    localparam int FEATURE_BITS_DEF = 1024;
    localparam int LANES_DEF        = 16;
    localparam int RATE_W           = 25;
    localparam int FRAME_W          = 16;
    localparam int WIDX_W           = 6;
    localparam int BITS_W           = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 25;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT    = 2'd2;

    typedef struct packed {
        logic                start;
        logic [FRAME_W-1:0]  divisor;
    } t_div_ctl;
endpackage
`default_nettype wire

// ----- hdl/btrm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btrm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module btrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ----- hdl/btrm_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btrm_lane
// One lane: restoring divider that forms (old*(f-1)+edge*2^24)/f one
// quotient bit per cycle. Dividend is below 2^41, quotient fits 25 bits.
// ----------------------------------------------------------------------------
module btrm_lane
    import btrm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_div_ctl            i_ctl,
    input  wire logic [RATE_W-1:0]   i_old,
    input  wire logic                i_edge,
    output logic [RATE_W-1:0]        o_rate,
    output logic                     o_busy
);
    localparam int DVD_W = RATE_W + FRAME_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]   r_dvd, n_dvd;
    logic [FRAME_W:0]   r_rem, n_rem;
    logic [DVD_W-1:0]   r_quo, n_quo;
    logic [FRAME_W-1:0] r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic [FRAME_W:0]   w_trial;
    logic [DVD_W-1:0]   w_prod;
    logic [FRAME_W-1:0] w_fm1;

    assign w_fm1  = i_ctl.divisor - FRAME_W'(1);
    assign w_prod = DVD_W'(i_old) * DVD_W'(w_fm1)
                  + (i_edge ? (DVD_W'(1) << 24) : DVD_W'(0));
    assign w_trial = {r_rem[FRAME_W-1:0], r_dvd[DVD_W-1]};

    always_comb begin
        n_dvd = {r_dvd[DVD_W-2:0], 1'b0};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = w_trial - {1'b0, r_div};
            n_quo = {r_quo[DVD_W-2:0], 1'b1};
        end else begin
            n_rem = w_trial;
            n_quo = {r_quo[DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.start) begin
            r_cnt <= CNT_W'(DVD_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_ctl.start) begin
            r_dvd <= w_prod;
            r_rem <= '0;
            r_quo <= '0;
            r_div <= i_ctl.divisor;
        end else if (r_cnt != '0) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rate = r_quo[RATE_W-1:0];
    assign o_busy = (r_cnt != '0);
endmodule
`default_nettype wire

// ----- hdl/btrm_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btrm_merge
// Combines lane rates into rare masks, report masks and the word's any-rare flag.
// ----------------------------------------------------------------------------
module btrm_merge
    import btrm_pkg::*;
#(
    parameter int LANES = LANES_DEF
) (
    input  wire logic [LANES*RATE_W-1:0] i_rise_rate,
    input  wire logic [LANES*RATE_W-1:0] i_fall_rate,
    input  wire logic [LANES-1:0]        i_rise,
    input  wire logic [LANES-1:0]        i_fall,
    input  wire logic                    i_past_warmup,
    input  wire logic [RATE_W-1:0]       i_threshold,
    input  wire logic                    i_report_all,
    output logic      [BITS_W-1:0]       o_rise_rare,
    output logic      [BITS_W-1:0]       o_fall_rare,
    output logic      [BITS_W-1:0]       o_report_rise,
    output logic      [BITS_W-1:0]       o_report_fall,
    output logic      [BITS_W-1:0]       o_rise,
    output logic      [BITS_W-1:0]       o_fall,
    output logic                         o_any_rare
);
    logic [BITS_W-1:0] w_rr, w_fr, w_r, w_f;
    always_comb begin
        w_rr = '0;
        w_fr = '0;
        w_r  = '0;
        w_f  = '0;
        for (int k = 0; k < LANES && k < BITS_W; k++) begin
            w_r[k]  = i_rise[k];
            w_f[k]  = i_fall[k];
            w_rr[k] = i_rise[k] && i_past_warmup
                   && (i_rise_rate[k*RATE_W +: RATE_W] < i_threshold);
            w_fr[k] = i_fall[k] && i_past_warmup
                   && (i_fall_rate[k*RATE_W +: RATE_W] < i_threshold);
        end
    end
    assign o_rise_rare   = w_rr;
    assign o_fall_rare   = w_fr;
    assign o_rise        = w_r;
    assign o_fall        = w_f;
    assign o_report_rise = i_report_all ? w_r : w_rr;
    assign o_report_fall = i_report_all ? w_f : w_fr;
    assign o_any_rare    = |{w_rr, w_fr};
endmodule
`default_nettype wire

// ----- hdl/bit_transition_rarity_monitor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bit_transition_rarity_monitor
// Per-bit rising/falling edge rates with rare-edge reporting.
// Usage: one request on s_axis carries one LANES-bit word of a frame's
// feature vector; one result per request leaves on m_axis. Configuration
// writes (threshold, warm-up, report_all) go over the cfg channel while idle.
// Per word: previous bits and both rate rows are read from RAM, all lanes
// divide in parallel in bit-serial lane dividers, one quotient bit per
// cycle, then rates are written back and the result is registered. One
// word is in work at a time; the next request is taken once the result
// has been stored in the output register, so a stalled receiver holds
// one result while the next word is computed.
// After reset the block clears the rate and previous-bit RAMs, one row
// per cycle, and accepts no word meanwhile.
// ----------------------------------------------------------------------------
module bit_transition_rarity_monitor
    import btrm_pkg::*;
#(
    parameter int FEATURE_BITS = FEATURE_BITS_DEF,
    parameter int LANES        = LANES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [5:0] word_index, [21:6] bits, [37:22] frame, [39:38] zero
    input  wire logic [39:0]           s_axis_tdata,
    // [0] episode_start
    input  wire logic                  s_axis_tuser,
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [5:0] out_word_index, [21:6] rise_mask, [37:22] fall_mask,
    // [53:38] rise_rare_mask, [69:54] fall_rare_mask, [85:70] report_rise,
    // [101:86] report_fall, [103:102] zero
    output logic [103:0]               m_axis_tdata,
    // [0] frame_any_rare
    output logic                       m_axis_tuser,
    output logic                       m_axis_tlast,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int WORDS  = (FEATURE_BITS + LANES - 1) / LANES;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int ROW_W  = LANES * RATE_W;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    logic [ADDR_W-1:0]  r_clr;
    logic [RATE_W-1:0]  r_thr;
    logic [FRAME_W-1:0] r_warm;
    logic               r_rep;
    logic               r_seen;
    logic [WIDX_W-1:0]  r_word;
    logic [BITS_W-1:0]  r_bits;
    logic [FRAME_W-1:0] r_frame;
    logic               r_start_ep, r_last, r_inrange;
    logic [LANES-1:0]   r_lane_ok;
    logic               r_go;

    logic               w_acc;
    logic               w_we;
    logic [ADDR_W-1:0]  w_addr;
    logic [BITS_W-1:0]  w_prev_rd, w_prev_wd;
    logic [ROW_W-1:0]   w_rr_rd, w_fr_rd, w_rr_wd, w_fr_wd, w_rnew, w_fnew;
    logic [LANES-1:0]   w_up, w_dn, w_busy, w_fbusy;
    logic [BITS_W-1:0]  w_prev;
    logic [FRAME_W-1:0] w_f;
    t_div_ctl           w_ctl;

    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= RATE_W'(16777);
            r_warm <= FRAME_W'(100);
            r_rep  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_THRESHOLD: r_thr  <= i_cfg_data;
                REG_WARMUP:    r_warm <= i_cfg_data[FRAME_W-1:0];
                REG_REPORT:    r_rep  <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_word     <= s_axis_tdata[5:0];
            r_bits     <= s_axis_tdata[21:6];
            r_frame    <= s_axis_tdata[37:22];
            r_start_ep <= s_axis_tuser;
            r_last     <= s_axis_tlast;
            r_inrange  <= (32'(s_axis_tdata[5:0]) < WORDS);
            for (int k = 0; k < LANES; k++) begin
                r_lane_ok[k] <= (32'(s_axis_tdata[5:0]) * LANES + k < FEATURE_BITS);
            end
        end
    end

    assign w_addr = (r_state == S_CLEAR) ? r_clr
                  : (w_acc ? ADDR_W'(s_axis_tdata[5:0]) : ADDR_W'(r_word));
    assign w_we   = (r_state == S_CLEAR) || (r_state == S_DONE && r_inrange);

    assign w_prev = r_start_ep ? '0 : w_prev_rd;
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (k < BITS_W) begin
                w_up[k] = r_lane_ok[k] && !w_prev[k] && r_bits[k];
                w_dn[k] = r_lane_ok[k] && w_prev[k] && !r_bits[k];
            end else begin
                w_up[k] = 1'b0;
                w_dn[k] = 1'b0;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_rr_wd[k*RATE_W +: RATE_W] = (r_state == S_CLEAR) ? '0
                : (r_lane_ok[k] ? w_rnew[k*RATE_W +: RATE_W] : w_rr_rd[k*RATE_W +: RATE_W]);
            w_fr_wd[k*RATE_W +: RATE_W] = (r_state == S_CLEAR) ? '0
                : (r_lane_ok[k] ? w_fnew[k*RATE_W +: RATE_W] : w_fr_rd[k*RATE_W +: RATE_W]);
        end
    end
    assign w_prev_wd = (r_state == S_CLEAR) ? '0 : r_bits;

    btrm_ram #(.WIDTH(BITS_W), .DEPTH(WORDS)) u_prev (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_prev_wd),
        .o_rdata(w_prev_rd));
    btrm_ram #(.WIDTH(ROW_W), .DEPTH(WORDS)) u_rise (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_rr_wd),
        .o_rdata(w_rr_rd));
    btrm_ram #(.WIDTH(ROW_W), .DEPTH(WORDS)) u_fall (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_fr_wd),
        .o_rdata(w_fr_rd));

    assign w_f   = (r_frame == '0) ? FRAME_W'(1) : r_frame;
    assign w_ctl = '{start: (r_state == S_READ), divisor: w_f};

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        btrm_lane u_rl (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
            .i_old(w_rr_rd[g*RATE_W +: RATE_W]), .i_edge(w_up[g]),
            .o_rate(w_rnew[g*RATE_W +: RATE_W]), .o_busy(w_busy[g]));
        btrm_lane u_fl (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
            .i_old(w_fr_rd[g*RATE_W +: RATE_W]), .i_edge(w_dn[g]),
            .o_rate(w_fnew[g*RATE_W +: RATE_W]), .o_busy(w_fbusy[g]));
    end

    logic [LANES-1:0]  r_up, r_dn;
    logic [BITS_W-1:0] w_rise, w_fall, w_rrare, w_frare, w_reprise, w_repfall;
    logic              w_any;

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_up <= w_up;
            r_dn <= w_dn;
        end
    end

    btrm_merge #(.LANES(LANES)) u_merge (
        .i_rise_rate(w_rnew), .i_fall_rate(w_fnew), .i_rise(r_up), .i_fall(r_dn),
        .i_past_warmup(r_frame > r_warm), .i_threshold(r_thr),
        .i_report_all(r_rep), .o_rise_rare(w_rrare), .o_fall_rare(w_frare),
        .o_report_rise(w_reprise), .o_report_fall(w_repfall),
        .o_rise(w_rise), .o_fall(w_fall), .o_any_rare(w_any));

    logic w_out_free;
    assign w_out_free = !m_axis_tvalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_seen        <= 1'b0;
            r_go          <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_go <= (r_state == S_READ);
            if (r_state == S_DONE && w_out_free) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (32'(r_clr) == WORDS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!r_go && (w_busy | w_fbusy) == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state       <= S_IDLE;
                        m_axis_tdata  <= {2'b00, w_repfall, w_reprise, w_frare, w_rrare,
                                          w_fall, w_rise, r_word};
                        m_axis_tlast  <= r_last;
                        m_axis_tuser  <= r_last && (r_seen || w_any);
                        r_seen        <= r_last ? 1'b0 : (r_seen || w_any);
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    // RAM writes happen only during clear or on write-back of an in-range word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("RAM write while idle");
    // No word is accepted while the dividers run.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_busy != '0) |-> !s_axis_tready)
        else $error("ready while dividing");
    // A result is issued only from the write-back state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_DONE))
        else $error("result issued outside write-back");
endmodule
`default_nettype wire
